// File: design/sapq_pkg.sv
`timescale 1ns / 1ps

package sapq_pkg;

   localparam int ValueWidth  = 32;
   localparam int StatusWidth = 2;
   localparam int OccWidth    = 4;

   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   localparam logic [StatusWidth-1:0] ST_DONE  = 2'd0;
   localparam logic [StatusWidth-1:0] ST_FULL  = 2'd1;
   localparam logic [StatusWidth-1:0] ST_EMPTY = 2'd2;

   localparam logic signed [ValueWidth-1:0] EMPTY_DATA = -32'sd1;

   typedef struct packed {
      logic                         action;
      logic signed [ValueWidth-1:0] value;
   } req_type;

   typedef struct packed {
      logic [StatusWidth-1:0]       status;
      logic signed [ValueWidth-1:0] data_out;
      logic [OccWidth-1:0]          occupancy;
   } rsp_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic                         insert;
      logic                         remove;
      logic signed [ValueWidth-1:0] value;
   } cell_ctl_type;

endpackage

// File: design/sapq_cell.sv
`timescale 1ns / 1ps

module sapq_cell
   import sapq_pkg::*;
(
   input  logic                         clock,
   input  cell_ctl_type                 ctl,
   input  logic                         occupied,
   input  logic                         left_le,
   input  logic signed [ValueWidth-1:0] left_value,
   input  logic signed [ValueWidth-1:0] right_value,
   output logic                         le,
   output logic signed [ValueWidth-1:0] value
);

   logic signed [ValueWidth-1:0] value_ff;
   logic signed [ValueWidth-1:0] value_in;

   // A cell whose value is less than or equal to the new one stays put. The
   // first cell past those takes the new value, and the rest shift up.
   assign le    = occupied && (value_ff <= ctl.value);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.insert) begin
         if (!le) begin
            if (left_le) begin
               value_in = ctl.value;
            end else begin
               value_in = left_value;
            end
         end
      end else if (ctl.remove) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// File: design/sorted_array_priority_queue.sv
`timescale 1ns / 1ps

// Sorted priority queue built as a row of DEPTH cells, smallest value in cell 0.
// A command beat is taken on a rising edge with start high and busy low; busy
// is always low, so one enqueue or dequeue is taken every cycle.
// An enqueue places its value behind every stored value that is less than or
// equal to it; all cells compare against the new value in parallel and each
// either holds, takes the new value or takes its left neighbor's value.
// A dequeue returns cell 0 and every cell takes its right neighbor's value.
// Enqueue on a full queue returns status full; dequeue on an empty queue
// returns status empty with data -1. The store is left unchanged in both.
// Each command gives exactly one response beat, in the cycle after it is taken:
// rsp_strobe is high for that single cycle and rsp_item holds status, data
// and the occupancy after the command. The receiver cannot stall the block.
// Synchronous reset empties the queue; cell contents are not cleared, since
// only cells below the occupancy count are ever read.
module sorted_array_priority_queue
   import sapq_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int CountWidth = $clog2(DEPTH + 1);

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   cell_ctl_type                 ctl;
   logic                         accept;
   logic                         full;
   logic                         empty;
   logic                         cell_le    [DEPTH];
   logic signed [ValueWidth-1:0] cell_value [DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CountWidth'(DEPTH));
   assign empty  = (count_ff == '0);

   assign ctl.insert = accept && (req_item.action == ACT_ENQUEUE) && !full;
   assign ctl.remove = accept && (req_item.action == ACT_DEQUEUE) && !empty;
   assign ctl.value  = req_item.value;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                         occupied;
      logic                         left_le;
      logic signed [ValueWidth-1:0] left_value;
      logic signed [ValueWidth-1:0] right_value;

      assign occupied = (count_ff > CountWidth'(i));

      if (i == 0) begin : g_first
         assign left_le    = 1'b1;
         assign left_value = req_item.value;
      end else begin : g_inner
         assign left_le    = cell_le[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_body
         assign right_value = cell_value[i+1];
      end

      sapq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occupied),
         .left_le     (left_le),
         .left_value  (left_value),
         .right_value (right_value),
         .le          (cell_le[i]),
         .value       (cell_value[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.insert) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.remove) begin
         count_in = count_ff - 1'b1;
      end

      rsp_in.status    = ST_DONE;
      rsp_in.data_out  = '0;
      rsp_in.occupancy = OccWidth'(count_in);
      if (req_item.action == ACT_ENQUEUE) begin
         if (full) begin
            rsp_in.status = ST_FULL;
         end
      end else begin
         if (empty) begin
            rsp_in.status   = ST_EMPTY;
            rsp_in.data_out = EMPTY_DATA;
         end else begin
            rsp_in.data_out = cell_value[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sapq_pkg::*;

   localparam int QueueDepth = 8;
   localparam int PhaseItems = 275;
   localparam int StallLimit = 2000;

   // Tracks the queue contents and the responses still owed by the block.
   class pq_response_tracker;
      logic signed [ValueWidth-1:0] stored_values [QueueDepth];
      int unsigned                  stored_count;
      rsp_type                      due_responses [$];
      int                           fail_count;

      function new();
         stored_count = 0;
         fail_count   = 0;
      endfunction

      function void note_command(req_type cmd);
         rsp_type                      want;
         logic signed [ValueWidth-1:0] v;
         int unsigned                  pos;
         v              = cmd.value;
         want.status    = ST_DONE;
         want.data_out  = '0;
         if (cmd.action == ACT_ENQUEUE) begin
            if (stored_count >= QueueDepth) begin
               want.status = ST_FULL;
            end else begin
               // Equal values go behind those already stored.
               pos = 0;
               while (pos < stored_count && stored_values[pos] <= v) pos++;
               for (int i = stored_count; i > pos; i--)
                  stored_values[i] = stored_values[i-1];
               stored_values[pos] = v;
               stored_count++;
            end
         end else begin
            if (stored_count == 0) begin
               want.status   = ST_EMPTY;
               want.data_out = EMPTY_DATA;
            end else begin
               want.data_out = stored_values[0];
               for (int i = 1; i < stored_count; i++)
                  stored_values[i-1] = stored_values[i];
               stored_count--;
            end
         end
         want.occupancy = stored_count[OccWidth-1:0];
         due_responses.push_back(want);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (due_responses.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, actual %h",
                     $time, got);
            fail_count++;
            return;
         end
         want = due_responses.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            fail_count++;
         end
         if (got.data_out !== want.data_out) begin
            $display("%0t: data_out mismatch, expected %0d, actual %0d",
                     $time, $signed(want.data_out), $signed(got.data_out));
            fail_count++;
         end
         if (got.occupancy !== want.occupancy) begin
            $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                     $time, want.occupancy, got.occupancy);
            fail_count++;
         end
      endfunction

      function int unsigned owed();
         return due_responses.size();
      endfunction

      function void check_drained();
         if (due_responses.size() != 0) begin
            $display("%0t: responses missing, expected %0d more, actual 0",
                     $time, due_responses.size());
            fail_count++;
         end
      endfunction
   endclass

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   pq_response_tracker tracker;
   int                 quiet_cycles = 0;
   int                 sender_idle_pct = 0;

   always #4 clock = ~clock;

   sorted_array_priority_queue #(
      .DEPTH(QueueDepth)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   // Inputs change only through nonblocking updates, so values read here are
   // the ones the block sees at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) tracker.check_response(rsp_item);
         if (start && !busy) tracker.note_command(req_item);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= StallLimit) begin
            $display("FAILED: results differ");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send(input logic action, input logic signed [ValueWidth-1:0] value);
      req_type cmd;
      cmd.action = action;
      cmd.value  = value;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= cmd;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (tracker.owed() != 0);
   endtask

   function automatic logic signed [ValueWidth-1:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom_range(15) - 8;
         1: case ($urandom_range(5))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return 32'sh8000_0001;
               3: return 32'sh7FFF_FFFE;
               4: return '0;
               default: return -32'sd1;
            endcase
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int enq_pct;
      int burst;
      int sent;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty dequeue, extremes, ties, fill to full, refusals, empty again.
      send(ACT_DEQUEUE, $urandom);
      send(ACT_ENQUEUE, 32'sh8000_0000);
      send(ACT_ENQUEUE, 32'sh7FFF_FFFF);
      send(ACT_ENQUEUE, '0);
      send(ACT_ENQUEUE, -32'sd1);
      send(ACT_ENQUEUE, 32'sd5);
      send(ACT_ENQUEUE, 32'sd5);
      send(ACT_ENQUEUE, -32'sd1);
      send(ACT_ENQUEUE, 32'sh8000_0000);
      send(ACT_ENQUEUE, 32'sd3);
      send(ACT_ENQUEUE, 32'sh7FFF_FFFF);
      repeat (QueueDepth) send(ACT_DEQUEUE, $urandom);
      send(ACT_DEQUEUE, $urandom);
      send(ACT_ENQUEUE, 32'sh7FFF_FFFF);
      send(ACT_DEQUEUE, '1);
      drain();

      // Random bursts, each leaning toward filling, emptying or balance.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: sender_idle_pct = 0;
            1: sender_idle_pct = 77;
            2: sender_idle_pct = 24;
            default: sender_idle_pct = 0;
         endcase
         sent = 0;
         while (sent < PhaseItems) begin
            case ($urandom_range(2))
               0: enq_pct = 25;
               1: enq_pct = 50;
               default: enq_pct = 75;
            endcase
            burst = $urandom_range(40, 8);
            for (int k = 0; k < burst; k++) begin
               if ($urandom_range(99) < enq_pct) send(ACT_ENQUEUE, pick_value());
               else send(ACT_DEQUEUE, $urandom);
            end
            sent += burst;
         end
         // Hold the sender until every response of this phase is back.
         drain();
      end

      repeat (4) @(posedge clock);
      tracker.check_drained();
      if (tracker.fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: sim.f
design/sapq_pkg.sv
design/sapq_cell.sv
design/sorted_array_priority_queue.sv
sim/tb_top.sv
